FILE: hdl/icwn_pkg.sv
`default_nettype none

package icwn_pkg;

    // Fill sequencer states: one pass per quarter-wave entry
    typedef enum logic [3:0] {
        FILL_XMUL,
        FILL_XSQ,
        FILL_X2,
        FILL_TMUL,
        FILL_RMUL,
        FILL_REM,
        FILL_CORR,
        FILL_OUT,
        FILL_DONE
    } fill_state_t;

    // Reset value of the conversion register (table size / sample rate, Q8.24)
    localparam logic [31:0] CONV_RESET = 32'd5726623;

    // pi/2 in Q30 and one in Q30
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    // Taylor series for the quarter-wave table
    localparam int TAYLOR_TERMS = 12;
    localparam int KW           = $clog2(TAYLOR_TERMS);

    // Term k divides by (2k-1)(2k)
    localparam logic [9:0] TERM_DIV [TAYLOR_TERMS] = '{
        10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
        10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
    };

    // floor(2^32 / divisor); quotient estimate is low by at most one
    localparam logic [31:0] TERM_RECIP [TAYLOR_TERMS] = '{
        32'(64'h1_0000_0000 / 64'd2),   32'(64'h1_0000_0000 / 64'd12),
        32'(64'h1_0000_0000 / 64'd30),  32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd90),  32'(64'h1_0000_0000 / 64'd132),
        32'(64'h1_0000_0000 / 64'd182), 32'(64'h1_0000_0000 / 64'd240),
        32'(64'h1_0000_0000 / 64'd306), 32'(64'h1_0000_0000 / 64'd380),
        32'(64'h1_0000_0000 / 64'd462), 32'(64'h1_0000_0000 / 64'd552)
    };

    // Remainder after the quotient estimate stays below twice the largest divisor
    localparam int REM_W = 11;

    // Running Taylor sum width (signed)
    localparam int SUM_W = 34;

    // Queue depths between the parts
    localparam int MID_DEPTH  = 4;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH) + 1;

endpackage

`default_nettype wire

FILE: hdl/icwn_ram.sv
`default_nettype none

module icwn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4097
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // One write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

FILE: hdl/icwn_fifo.sv
`default_nettype none

module icwn_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     pop,
    output logic [WIDTH-1:0]         rdata,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Requests are ignored when they cannot be served
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/icwn_rom_fill.sv
`default_nettype none

module icwn_rom_fill #(
    parameter int TABLE_BITS  = 14,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    ram_we,
    output logic [TABLE_BITS-2:0]   ram_waddr,
    output logic [SAMPLE_BITS-1:0]  ram_wdata,
    output logic                    done
);

    import icwn_pkg::*;

    localparam int QB  = TABLE_BITS - 2;
    localparam int MW  = TABLE_BITS - 1;
    localparam int V_W = 31 + SAMPLE_BITS;

    localparam logic [MW-1:0]          M_LAST   = MW'(2**QB);
    localparam logic [KW-1:0]          K_LAST   = KW'(TAYLOR_TERMS - 1);
    localparam logic [63:0]            X_HALF   = 64'd1 << (QB - 1);
    localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(ONE_Q30);
    localparam logic [V_W-1:0]         V_HALF   = V_W'(64'd1 << 29);
    localparam logic [V_W-1:0]         V_FULL   = V_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    fill_state_t              state_reg, state_next;
    logic [MW-1:0]            m_reg, m_next;
    logic [KW-1:0]            k_reg, k_next;
    logic [63:0]              mul_reg, mul_next;
    logic [31:0]              x2_reg, x2_next;
    logic [31:0]              term_reg, term_next;
    logic [31:0]              t_reg, t_next;
    logic [31:0]              q0_reg, q0_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [31:0]              x_val;
    logic [31:0]              qd;
    logic [31:0]              term_val;
    logic [30:0]              sum_c;
    logic [V_W-1:0]           v_sum;
    logic [V_W-1:0]           v_val;

    // Shared 32x32 multiplier, product registered every cycle
    assign mul_next = {32'b0, mul_a} * {32'b0, mul_b};

    // Angle in Q30, rounded
    assign x_val = 32'((mul_reg + X_HALF) >> QB);

    // Quotient estimate times divisor, remainder check
    assign qd       = mul_reg[63:32] * 32'(TERM_DIV[k_reg]);
    assign term_val = (rem_reg >= REM_W'(TERM_DIV[k_reg])) ? q0_reg + 32'd1 : q0_reg;

    // Clamp to [0, 1] and scale to the sample format
    always_comb
    begin
        if (sum_reg < 0)
        begin
            sum_c = '0;
        end
        else if (sum_reg > SUM_ONE)
        begin
            sum_c = 31'(ONE_Q30);
        end
        else
        begin
            sum_c = 31'(sum_reg);
        end
        v_sum = (V_W'(sum_c) << (SAMPLE_BITS - 1)) + V_HALF;
        v_val = v_sum >> 30;
    end

    // Next state
    always_comb
    begin
        case (state_reg)
            FILL_XMUL: state_next = FILL_XSQ;
            FILL_XSQ:  state_next = FILL_X2;
            FILL_X2:   state_next = FILL_TMUL;
            FILL_TMUL: state_next = FILL_RMUL;
            FILL_RMUL: state_next = FILL_REM;
            FILL_REM:  state_next = FILL_CORR;
            FILL_CORR: state_next = (k_reg == K_LAST) ? FILL_OUT : FILL_TMUL;
            FILL_OUT:  state_next = (m_reg == M_LAST) ? FILL_DONE : FILL_XMUL;
            FILL_DONE: state_next = FILL_DONE;
            default:   state_next = FILL_XMUL;
        endcase
    end

    // Datapath controls per state
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        m_next    = m_reg;
        k_next    = k_reg;
        x2_next   = x2_reg;
        term_next = term_reg;
        t_next    = t_reg;
        q0_next   = q0_reg;
        rem_next  = rem_reg;
        sum_next  = sum_reg;
        ram_we    = 1'b0;
        case (state_reg)
            FILL_XMUL:
            begin
                mul_a = HALF_PI_Q30;
                mul_b = 32'(m_reg);
            end
            FILL_XSQ:
            begin
                mul_a     = x_val;
                mul_b     = x_val;
                term_next = ONE_Q30;
                sum_next  = SUM_ONE;
                k_next    = '0;
            end
            FILL_X2:
            begin
                x2_next = mul_reg[61:30];
            end
            FILL_TMUL:
            begin
                mul_a = term_reg;
                mul_b = x2_reg;
            end
            FILL_RMUL:
            begin
                mul_a  = mul_reg[61:30];
                mul_b  = TERM_RECIP[k_reg];
                t_next = mul_reg[61:30];
            end
            FILL_REM:
            begin
                q0_next  = mul_reg[63:32];
                rem_next = REM_W'(t_reg - qd);
            end
            FILL_CORR:
            begin
                term_next = term_val;
                // first term (k_reg zero) subtracts, signs alternate
                if (!k_reg[0])
                begin
                    sum_next = sum_reg - $signed({2'b00, term_val});
                end
                else
                begin
                    sum_next = sum_reg + $signed({2'b00, term_val});
                end
                k_next = k_reg + 1'b1;
            end
            FILL_OUT:
            begin
                ram_we = 1'b1;
                m_next = m_reg + 1'b1;
            end
            FILL_DONE:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_waddr = m_reg;
    assign ram_wdata = (v_val > V_FULL) ? SAMPLE_BITS'(V_FULL) : SAMPLE_BITS'(v_val);
    assign done      = (state_reg == FILL_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FILL_XMUL;
            m_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
        end
    end

    // Arithmetic registers
    always_ff @(posedge clk)
    begin
        mul_reg  <= mul_next;
        x2_reg   <= x2_next;
        term_reg <= term_next;
        t_reg    <= t_next;
        q0_reg   <= q0_next;
        rem_reg  <= rem_next;
        sum_reg  <= sum_next;
    end

endmodule

`default_nettype wire

FILE: hdl/icwn_front.sv
`default_nettype none

module icwn_front #(
    parameter int TABLE_BITS      = 14,
    parameter int PHASE_FRAC_BITS = 18
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    conv_we,
    input  logic [31:0]                             conv_data,
    input  logic                                    push,
    input  logic signed [23:0]                      frequency,
    output logic                                    full,
    input  logic                                    fill_done,
    input  logic                                    mid_full,
    output logic                                    mid_push,
    output logic [TABLE_BITS+PHASE_FRAC_BITS-1:0]   mid_phase
);

    import icwn_pkg::*;

    localparam int PB      = TABLE_BITS + PHASE_FRAC_BITS;
    localparam int INC_LSB = 32 - PHASE_FRAC_BITS;

    logic [31:0]        conv_reg, conv_next;
    logic [PB-1:0]      phase_reg, phase_next;
    logic [PB-1:0]      inc_reg, inc_next;
    logic               pend_reg, pend_next;
    logic signed [56:0] prod;
    logic [PB-1:0]      cur_phase;
    logic               accept;

    // Stall while the table is being built or the queue is full
    assign full   = !fill_done || mid_full;
    assign accept = push && !full;

    // Q24.32 increment; the slice is the floor shift modulo the accumulator
    assign prod = frequency * $signed({1'b0, conv_reg});

    // Phase seen by this request folds in the previous request's increment
    assign cur_phase = phase_reg + (pend_reg ? inc_reg : '0);

    always_comb
    begin
        conv_next  = conv_we ? conv_data : conv_reg;
        phase_next = cur_phase;
        inc_next   = accept ? prod[INC_LSB +: PB] : inc_reg;
        pend_next  = accept;
    end

    assign mid_push  = accept;
    assign mid_phase = cur_phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_reg  <= CONV_RESET;
            phase_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            conv_reg  <= conv_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg <= inc_next;
    end

endmodule

`default_nettype wire

FILE: hdl/icwn_back.sv
`default_nettype none

module icwn_back #(
    parameter int TABLE_BITS      = 14,
    parameter int PHASE_FRAC_BITS = 18,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    mid_empty,
    input  logic [TABLE_BITS+PHASE_FRAC_BITS-1:0]   mid_phase,
    output logic                                    mid_pop,
    output logic [TABLE_BITS-2:0]                   ram_raddr_a,
    output logic [TABLE_BITS-2:0]                   ram_raddr_b,
    input  logic [SAMPLE_BITS-1:0]                  ram_rdata_a,
    input  logic [SAMPLE_BITS-1:0]                  ram_rdata_b,
    input  logic [icwn_pkg::OUT_CNT_W-1:0]          out_count,
    output logic                                    out_push,
    output logic [SAMPLE_BITS-1:0]                  out_sample
);

    import icwn_pkg::*;

    localparam int TB   = TABLE_BITS;
    localparam int PFB  = PHASE_FRAC_BITS;
    localparam int PB   = TB + PFB;
    localparam int AW   = TB - 1;
    localparam int QTR  = 2**(TB - 2);
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int DFW  = SAMPLE_BITS + 2;
    localparam int PW   = SAMPLE_BITS + PFB + 3;

    localparam logic [TB:0] Q1 = (TB+1)'(QTR);
    localparam logic [TB:0] Q2 = (TB+1)'(2 * QTR);
    localparam logic [TB:0] Q3 = (TB+1)'(3 * QTR);
    localparam logic [TB:0] Q4 = (TB+1)'(4 * QTR);
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (PFB - 1));

    // Map a full-wave index to {negate, quarter-wave address}
    function automatic logic [AW:0] quarter_map(input logic [TB-1:0] j);
        logic [TB:0] jx;
        jx = {1'b0, j};
        if (jx <= Q1)
        begin
            quarter_map = {1'b0, AW'(jx)};
        end
        else if (jx <= Q2)
        begin
            quarter_map = {1'b1, AW'(Q2 - jx)};
        end
        else if (jx <= Q3)
        begin
            quarter_map = {1'b1, AW'(jx - Q2)};
        end
        else
        begin
            quarter_map = {1'b0, AW'(Q4 - jx)};
        end
    endfunction

    logic [TB-1:0]              idx;
    logic [TB-1:0]              idx_n;
    logic [AW:0]                map_a;
    logic [AW:0]                map_b;
    logic [1:0]                 inflight;
    logic                       credit;
    logic                       issue;

    logic                       v1_reg, v2_reg, v3_reg;
    logic [PFB-1:0]             frac1_reg, frac1_next;
    logic                       nega1_reg, nega1_next;
    logic                       negb1_reg, negb1_next;
    logic signed [DW-1:0]       fa, fb;
    logic signed [DFW-1:0]      diff2_reg, diff2_next;
    logic signed [DW-1:0]       f12_reg;
    logic [PFB-1:0]             frac2_reg;
    logic signed [PW-1:0]       p3_reg, p3_next;
    logic signed [DW-1:0]       f13_reg;
    logic signed [PW-1:0]       s_full;

    // Table addresses of the two neighbors
    assign idx   = mid_phase[PB-1:PFB];
    assign idx_n = idx + 1'b1;
    assign map_a = quarter_map(idx);
    assign map_b = quarter_map(idx_n);

    // Issue only when the output queue has room for everything in flight
    assign inflight = {1'b0, v1_reg} + {1'b0, v2_reg} + {1'b0, v3_reg};
    assign credit   = ({1'b0, out_count} + (OUT_CNT_W+1)'(inflight))
                      < (OUT_CNT_W+1)'(OUT_DEPTH);
    assign issue    = !mid_empty && credit;
    assign mid_pop  = issue;

    assign ram_raddr_a = map_a[AW-1:0];
    assign ram_raddr_b = map_b[AW-1:0];

    assign frac1_next = mid_phase[PFB-1:0];
    assign nega1_next = map_a[AW];
    assign negb1_next = map_b[AW];

    // Stage 2: signed neighbors and their difference
    assign fa         = nega1_reg ? -$signed({1'b0, ram_rdata_a}) : $signed({1'b0, ram_rdata_a});
    assign fb         = negb1_reg ? -$signed({1'b0, ram_rdata_b}) : $signed({1'b0, ram_rdata_b});
    assign diff2_next = DFW'(fb) - DFW'(fa);

    // Stage 3: slope times fraction, rounded half up
    assign p3_next = diff2_reg * $signed({1'b0, frac2_reg}) + HALF;

    // Stage 4: floor shift and add the base
    assign s_full     = PW'(f13_reg) + (p3_reg >>> PFB);
    assign out_push   = v3_reg;
    assign out_sample = s_full[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        frac1_reg <= frac1_next;
        nega1_reg <= nega1_next;
        negb1_reg <= negb1_next;
        diff2_reg <= diff2_next;
        f12_reg   <= fa;
        frac2_reg <= frac1_reg;
        p3_reg    <= p3_next;
        f13_reg   <= f12_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/interpolated_cosine_wavetable_nco.sv
// Cosine oscillator with a linearly interpolated quarter-wave table.
// Input channel: one frequency request (signed Q16.8 Hz) per push; a request
// is taken at a clock edge with push high and full low. Result channel:
// the oldest sample (signed Q1.15) sits on sample while empty is low and is
// taken at an edge with pop high and empty low.
// conv (unsigned Q8.24, table size / sample rate) is written at any edge with
// conv_we high; write it only while no request is in flight.
// Throughput: one request per cycle while full is low, set by the phase add
// and the two-port table read. A result becomes visible once its request has
// passed the queue, table read, subtract, multiply and add.
// Reset: phase clears, conv returns to its default, and the table is rebuilt
// by a sequencer over 2^(TABLE_BITS-2)+1 entries, each one computed from a
// Taylor series; full stays high until the build is done.
// A stalled receiver fills an 8-entry result queue, then a 4-entry queue
// between front and back, then full rises; nothing is dropped.
`default_nettype none

module interpolated_cosine_wavetable_nco #(
    parameter int TABLE_BITS      = 14,
    parameter int PHASE_FRAC_BITS = 18,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           conv_we,
    input  logic [31:0]                    conv_data,
    input  logic                           push,
    input  logic signed [23:0]             frequency,
    output logic                           full,
    input  logic                           pop,
    output logic                           empty,
    output logic signed [SAMPLE_BITS-1:0]  sample
);

    import icwn_pkg::*;

    localparam int PB        = TABLE_BITS + PHASE_FRAC_BITS;
    localparam int ROM_DEPTH = 2**(TABLE_BITS - 2) + 1;
    localparam int MID_CNT_W = $clog2(MID_DEPTH) + 1;

    logic                       fill_done;
    logic                       ram_we;
    logic [TABLE_BITS-2:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0]     ram_wdata;
    logic [TABLE_BITS-2:0]      ram_raddr_a;
    logic [TABLE_BITS-2:0]      ram_raddr_b;
    logic [SAMPLE_BITS-1:0]     ram_rdata_a;
    logic [SAMPLE_BITS-1:0]     ram_rdata_b;
    logic                       mid_push;
    logic [PB-1:0]              mid_wphase;
    logic                       mid_pop;
    logic [PB-1:0]              mid_rphase;
    logic                       mid_full;
    logic                       mid_empty;
    logic [MID_CNT_W-1:0]       mid_count;
    logic                       out_push;
    logic [SAMPLE_BITS-1:0]     out_sample;
    logic                       out_full;
    logic [OUT_CNT_W-1:0]       out_count;
    logic [SAMPLE_BITS-1:0]     out_rdata;

    // Quarter-wave table builder
    icwn_rom_fill #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .done      (fill_done)
    );

    // Quarter-wave table storage
    icwn_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Front: accepts requests, runs the phase accumulator
    icwn_front #(
        .TABLE_BITS      (TABLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv_we   (conv_we),
        .conv_data (conv_data),
        .push      (push),
        .frequency (frequency),
        .full      (full),
        .fill_done (fill_done),
        .mid_full  (mid_full),
        .mid_push  (mid_push),
        .mid_phase (mid_wphase)
    );

    // Phase queue between front and back
    icwn_fifo #(
        .WIDTH (PB),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wphase),
        .pop   (mid_pop),
        .rdata (mid_rphase),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    // Back: table lookup and interpolation
    icwn_back #(
        .TABLE_BITS      (TABLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mid_empty   (mid_empty),
        .mid_phase   (mid_rphase),
        .mid_pop     (mid_pop),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .out_count   (out_count),
        .out_push    (out_push),
        .out_sample  (out_sample)
    );

    // Result queue
    icwn_fifo #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_sample),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    assign sample = $signed(out_rdata);

    // Credit scheme never lets a finished sample hit a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) out_push |-> !out_full)
        else $error("result queue overflow");

    // Table build finishes once and stays finished
    assert property (@(posedge clk) disable iff (!rst_n) fill_done |=> fill_done)
        else $error("table build restarted");

    // No table read before the build is complete
    assert property (@(posedge clk) disable iff (!rst_n) mid_pop |-> fill_done)
        else $error("lookup issued during table build");

    // No request taken while the table is being built
    assert property (@(posedge clk) disable iff (!rst_n) mid_push |-> fill_done)
        else $error("request taken during table build");

    // Front never pushes into a full phase queue
    assert property (@(posedge clk) disable iff (!rst_n)
                     mid_push |-> (mid_count < MID_CNT_W'(MID_DEPTH)))
        else $error("phase queue overflow");

endmodule

`default_nettype wire

FILE: tb/interpolated_cosine_wavetable_nco_test.sv
// Expected cosine samples: own copy of phase, conv and the cosine table
class cosine_scoreboard;
    localparam int          TBL_BITS   = 14;
    localparam int          FRAC_BITS  = 18;
    localparam int          TBL_LEN    = 1 << TBL_BITS;
    localparam int          QUARTER    = TBL_LEN / 4;
    localparam int          ROM_LEN    = TBL_LEN + 1;
    localparam int          FULL_SCALE = 32767;
    localparam longint      HALF_PI    = 64'd1686629713;
    localparam longint      ONE        = 64'd1 << 30;
    localparam logic [31:0] CONV_DEFAULT = 32'd5726623;

    int          rom [ROM_LEN];
    logic [31:0] conv;
    logic [31:0] phase;
    logic [15:0] pending_samples [$];
    int          errors;

    function new();
        int j;
        for (int i = 0; i < ROM_LEN; i++)
        begin
            j = i & (TBL_LEN - 1);
            if (j <= QUARTER)
                rom[i] = quarter_cos(j);
            else if (j <= 2 * QUARTER)
                rom[i] = -quarter_cos(2 * QUARTER - j);
            else if (j <= 3 * QUARTER)
                rom[i] = -quarter_cos(j - 2 * QUARTER);
            else
                rom[i] = quarter_cos(TBL_LEN - j);
        end
        conv   = CONV_DEFAULT;
        phase  = '0;
        errors = 0;
    endfunction

    // Q30 Taylor series of cos over the first quadrant, rounded to Q1.15
    function int quarter_cos(int m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        x    = (HALF_PI * longint'(m) + 64'd2048) >> (TBL_BITS - 2);
        x2   = (x * x) >> 30;
        term = ONE;
        sum  = ONE;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * x2) >> 30;
            term = term / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE)
            sum = ONE;
        v = ((longint'(sum) << 15) + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return int'(v);
    endfunction

    // Interpolate at the current phase, then advance the phase
    function void note_frequency(logic [23:0] freq);
        int     idx;
        longint frac;
        longint f1;
        longint f2;
        longint p;
        longint s;
        longint inc;
        longint fs;
        idx  = int'(phase >> FRAC_BITS) & (TBL_LEN - 1);
        frac = longint'(phase & ((32'd1 << FRAC_BITS) - 1));
        f1   = rom[idx];
        f2   = rom[idx + 1];
        p    = (f2 - f1) * frac + (64'sd1 <<< (FRAC_BITS - 1));
        s    = f1 + (p >>> FRAC_BITS);
        pending_samples.push_back(s[15:0]);
        fs    = longint'($signed(freq));
        inc   = (fs * longint'(conv)) >>> (32 - FRAC_BITS);
        phase = phase + inc[31:0];
    endfunction

    function void check_sample(logic [15:0] got);
        logic [15:0] want;
        if (pending_samples.size() == 0)
        begin
            $error("sample: unexpected result, actual %0d", $signed(got));
            errors++;
        end
        else
        begin
            want = pending_samples.pop_front();
            if (got !== want)
            begin
                $error("sample: expected %0d, actual %0d", $signed(want), $signed(got));
                errors++;
            end
        end
    endfunction
endclass

module interpolated_cosine_wavetable_nco_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] CONV_DEFAULT = 32'd5726623;
    localparam logic [31:0] CONV_UNITY   = 32'h0100_0000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        conv_we;
    logic [31:0] conv_data;
    logic        push;
    logic [23:0] frequency;
    logic        full;
    logic        pop;
    logic        empty;
    logic [15:0] sample;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    cosine_scoreboard board = new();

    interpolated_cosine_wavetable_nco dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv_we   (conv_we),
        .conv_data (conv_data),
        .push      (push),
        .frequency (frequency),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .sample    (sample)
    );

    always #5 clk = ~clk;

    // Run limit, well past the table fill after reset
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge
    task automatic write_conv(input logic [31:0] value);
        conv_we   <= 1'b1;
        conv_data <= value;
        @(posedge clk);
        board.conv = value;
        @(negedge clk);
        conv_we <= 1'b0;
    endtask

    // Offer one request; push stays high for a following request
    task automatic send_frequency(input logic [23:0] freq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        frequency <= freq;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_frequency(freq);
        @(negedge clk);
    endtask

    task automatic drain_samples();
        while (board.pending_samples.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [23:0] random_frequency();
        int sel;
        int val;
        sel = $urandom_range(9);
        if (sel <= 4)
            return 24'($urandom);
        if (sel <= 7)
        begin
            // audio band, +-20 kHz
            val = int'($urandom_range(0, 10240000)) - 5120000;
            return val[23:0];
        end
        if (sel == 8)
        begin
            case ($urandom_range(4))
                0:       return 24'h7F_FFFF;
                1:       return 24'h80_0000;
                2:       return 24'h00_0000;
                3:       return 24'hFF_FFFF;
                default: return 24'h00_0001;
            endcase
        end
        val = int'($urandom_range(0, 510)) - 255;
        return val[23:0];
    endfunction

    // Result side: random pop, or a counted hold-off when requested
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (pop && empty === 1'b0)
                board.check_sample(sample);
        end
    end

    initial
    begin
        logic [23:0] unity_cases [$];
        logic [23:0] default_cases [$];
        logic [31:0] conv_sets [6];

        rst_n     = 1'b0;
        conv_we   = 1'b0;
        conv_data = '0;
        push      = 1'b0;
        frequency = '0;

        // unity conv: half turn lands on -1.0, then a tie at half a step
        unity_cases = '{24'h00_0000, 24'h20_0000, 24'h00_0000, 24'h00_0080, 24'h00_0000,
                        24'hFF_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h00_0001, 24'h55_5555,
                        24'hAA_AAAA};
        default_cases = '{24'h01_B800, 24'hFE_4800, 24'h00_0000, 24'h7F_FFFF, 24'h80_0000};
        conv_sets = '{CONV_DEFAULT, 32'hFFFF_FFFF, 32'h0000_0000, $urandom,
                      CONV_UNITY, $urandom_range(1, 32'h0200_0000)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests
        write_conv(CONV_UNITY);
        foreach (unity_cases[i])
            send_frequency(unity_cases[i]);
        push <= 1'b0;
        drain_samples();

        write_conv(CONV_DEFAULT);
        foreach (default_cases[i])
            send_frequency(default_cases[i]);
        push <= 1'b0;
        drain_samples();

        // random requests under several conv settings and idle mixes
        for (int p = 0; p < 6; p++)
        begin
            write_conv(conv_sets[p]);
            if (p < 2)
            begin
                send_idle_pct = 23;
                recv_idle_pct = 81;
            end
            else if (p < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 23;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall so the queues fill and full rises
            if (p == 4)
                hold_cycles = 64;
            repeat (134)
                send_frequency(random_frequency());
            push <= 1'b0;
            drain_samples();
        end

        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending_samples.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
